@@ sv/salience_slot_table_core_defines.svh @@
// assertion macros for the salience slot table
// used by the datapath, no other dependencies
`ifndef SALIENCE_SLOT_TABLE_CORE_DEFINES_SVH
`define SALIENCE_SLOT_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SST_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sst: invariant violated");
`define SST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sst: sequence check failed");
`else
`define SST_ASSERT(lbl, clk, rst, prop)
`define SST_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ sv/sst_pkg.sv @@
// shared types and constants for the salience slot table
// no dependencies
package sst_pkg;

   localparam int CMD_W    = 2;
   localparam int NODE_W   = 32;
   localparam int SAL_W    = 16;
   localparam int OUTC_W   = 3;
   localparam int SLOTO_W  = 4;
   localparam int OCC_W    = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam logic [SAL_W-1:0] ONE_Q15 = 16'h8000;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DECAY  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [OUTC_W-1:0] OUT_REINFORCED = 3'd0;
   localparam logic [OUTC_W-1:0] OUT_ADDED      = 3'd1;
   localparam logic [OUTC_W-1:0] OUT_REPLACED   = 3'd2;
   localparam logic [OUTC_W-1:0] OUT_REJECTED   = 3'd3;
   localparam logic [OUTC_W-1:0] OUT_DECAYED    = 3'd4;
   localparam logic [OUTC_W-1:0] OUT_CLEARED    = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_DECAY_FACTOR   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEEP_THRESHOLD = 1'd1;

   localparam logic [CSR_DAT_W-1:0] DECAY_FACTOR_RST   = 16'd52429;
   localparam logic [CSR_DAT_W-1:0] KEEP_THRESHOLD_RST = 16'd1638;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_en;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic sweep_done;
      logic pipe_busy;
      logic out_busy;
   } sts_type;

endpackage

@@ sv/sst_if.sv @@
// request, response and register write channels of the salience slot table
// depends on sst_pkg
interface sst_req_if import sst_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [NODE_W-1:0]   node_id;
   logic [SAL_W-1:0]    salience;

   modport source (output valid, command, node_id, salience, input ready);
   modport sink   (input valid, command, node_id, salience, output ready);
endinterface

interface sst_rsp_if import sst_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OUTC_W-1:0]   outcome;
   logic [SLOTO_W-1:0]  slot_index;
   logic [NODE_W-1:0]   displaced_node;
   logic [OCC_W-1:0]    occupied;

   modport source (output valid, outcome, slot_index, displaced_node, occupied,
                   input ready);
   modport sink   (input valid, outcome, slot_index, displaced_node, occupied,
                   output ready);
endinterface

interface sst_csr_if import sst_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/sst_ctrl.sv @@
// sequencing state machine for the salience slot table
// depends on sst_pkg, drives the datapath through ctl_type commands
module sst_ctrl import sst_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (sts.sweep_done) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!sts.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      ctl        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         ST_SWEEP: begin
            ctl.rd_en = !sts.sweep_done;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            ctl.finish = !sts.out_busy;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ sv/sst_dpath.sv @@
// slot memories, sweep pipeline, decay multiplier and result register
// depends on sst_pkg and the assertion macro header
`include "salience_slot_table_core_defines.svh"
module sst_dpath import sst_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl,
   output sts_type              sts,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [NODE_W-1:0]    req_node_id,
   input  logic [SAL_W-1:0]     req_salience,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OUTC_W-1:0]    rsp_outcome,
   output logic [SLOTO_W-1:0]   rsp_slot_index,
   output logic [NODE_W-1:0]    rsp_displaced_node,
   output logic [OCC_W-1:0]     rsp_occupied
);

   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   logic [NODE_W-1:0] node_mem [SLOTS];
   logic [SAL_W-1:0]  wt_mem   [SLOTS];

   // captured request
   logic [CMD_W-1:0]  cmd_ff;
   logic [NODE_W-1:0] id_ff;
   logic [SAL_W-1:0]  sal_ff;

   logic [CW-1:0] ptr_ff, k_ff, k_in, used_ff, used_in;
   logic [CSR_DAT_W-1:0] factor_ff, thr_ff;

   // stage 1: registered memory read
   logic              v1_ff;
   logic [NODE_W-1:0] rd_node_ff;
   logic [SAL_W-1:0]  rd_wt_ff;
   logic [AW-1:0]     idx1_ff;

   // stage 2: decay product
   logic              v2_ff;
   logic [NODE_W-1:0] node2_ff;
   logic [2*SAL_W-1:0] prod_ff;
   logic [SAL_W-1:0]  w2;
   logic              keep;

   // insert search results
   logic              hit_ff, min_ok_ff;
   logic [AW-1:0]     hit_idx_ff, min_idx_ff;
   logic [SAL_W-1:0]  hit_wt_ff, min_wt_ff;
   logic [NODE_W-1:0] min_node_ff;

   // memory write port
   logic              we;
   logic [AW-1:0]     waddr;
   logic [NODE_W-1:0] wnode;
   logic [SAL_W-1:0]  wwt;

   logic [SAL_W:0]    sum;
   logic [OUTC_W-1:0] fin_outcome;
   logic [AW-1:0]     fin_slot;
   logic [NODE_W-1:0] fin_disp;
   logic              fin_emit;

   logic              out_valid_ff;
   logic [OUTC_W-1:0] out_outcome_ff;
   logic [SLOTO_W-1:0] out_slot_ff;
   logic [NODE_W-1:0] out_disp_ff;
   logic [OCC_W-1:0]  out_occ_ff;

   assign w2   = prod_ff[2*SAL_W-1:SAL_W];
   assign keep = v2_ff && (w2 > thr_ff);
   assign sum  = {1'b0, hit_wt_ff} + {1'b0, sal_ff};

   assign sts.sweep_done = (ptr_ff == used_ff) || (cmd_ff != CMD_INSERT && cmd_ff != CMD_DECAY);
   assign sts.pipe_busy  = v1_ff || v2_ff;
   assign sts.out_busy   = out_valid_ff && !rsp_ready;

   always_comb begin
      we          = keep;
      waddr       = k_ff[AW-1:0];
      wnode       = node2_ff;
      wwt         = w2;
      k_in        = keep ? k_ff + CW'(1) : k_ff;
      used_in     = used_ff;
      fin_emit    = 1'b0;
      fin_outcome = OUT_REJECTED;
      fin_slot    = '0;
      fin_disp    = '0;
      if (ctl.load) k_in = '0;
      if (ctl.finish) begin
         case (cmd_ff)
            CMD_INSERT: begin
               fin_emit = 1'b1;
               if (hit_ff) begin
                  we          = 1'b1;
                  waddr       = hit_idx_ff;
                  wnode       = id_ff;
                  wwt         = (sum > {1'b0, ONE_Q15}) ? ONE_Q15 : sum[SAL_W-1:0];
                  fin_outcome = OUT_REINFORCED;
                  fin_slot    = hit_idx_ff;
               end else if (used_ff < CW'(SLOTS)) begin
                  we          = 1'b1;
                  waddr       = used_ff[AW-1:0];
                  wnode       = id_ff;
                  wwt         = sal_ff;
                  used_in     = used_ff + CW'(1);
                  fin_outcome = OUT_ADDED;
                  fin_slot    = used_ff[AW-1:0];
               end else if (sal_ff > min_wt_ff) begin
                  we          = 1'b1;
                  waddr       = min_idx_ff;
                  wnode       = id_ff;
                  wwt         = sal_ff;
                  fin_outcome = OUT_REPLACED;
                  fin_slot    = min_idx_ff;
                  fin_disp    = min_node_ff;
               end
            end
            CMD_DECAY: begin
               fin_emit    = 1'b1;
               used_in     = k_ff;
               fin_outcome = OUT_DECAYED;
            end
            CMD_CLEAR: begin
               fin_emit    = 1'b1;
               used_in     = '0;
               fin_outcome = OUT_CLEARED;
            end
            default: begin
            end
         endcase
      end
   end

   // memories: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         node_mem[waddr] <= wnode;
         wt_mem[waddr]   <= wwt;
      end
      if (ctl.rd_en) begin
         rd_node_ff <= node_mem[ptr_ff[AW-1:0]];
         rd_wt_ff   <= wt_mem[ptr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         id_ff  <= req_node_id;
         sal_ff <= (req_salience > ONE_Q15) ? ONE_Q15 : req_salience;
      end
      idx1_ff  <= ptr_ff[AW-1:0];
      node2_ff <= rd_node_ff;
      prod_ff  <= rd_wt_ff * factor_ff;
      if (v1_ff && cmd_ff == CMD_INSERT) begin
         if (!hit_ff && rd_node_ff == id_ff) begin
            hit_idx_ff <= idx1_ff;
            hit_wt_ff  <= rd_wt_ff;
         end
         // strict compare keeps the first slot of lowest salience
         if (!min_ok_ff || rd_wt_ff < min_wt_ff) begin
            min_idx_ff  <= idx1_ff;
            min_wt_ff   <= rd_wt_ff;
            min_node_ff <= rd_node_ff;
         end
      end
      if (ctl.finish && fin_emit) begin
         out_outcome_ff <= fin_outcome;
         out_slot_ff    <= SLOTO_W'(fin_slot);
         out_disp_ff    <= fin_disp;
         out_occ_ff     <= OCC_W'(used_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= CMD_CLEAR;
         ptr_ff       <= '0;
         k_ff         <= '0;
         used_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         hit_ff       <= 1'b0;
         min_ok_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         factor_ff    <= DECAY_FACTOR_RST;
         thr_ff       <= KEEP_THRESHOLD_RST;
      end else begin
         if (ctl.load) begin
            cmd_ff <= req_command;
            ptr_ff <= '0;
         end else if (ctl.rd_en) begin
            ptr_ff <= ptr_ff + CW'(1);
         end
         k_ff    <= k_in;
         used_ff <= used_in;
         v1_ff   <= ctl.rd_en;
         v2_ff   <= v1_ff && cmd_ff == CMD_DECAY;
         if (ctl.load) begin
            hit_ff    <= 1'b0;
            min_ok_ff <= 1'b0;
         end else if (v1_ff && cmd_ff == CMD_INSERT) begin
            min_ok_ff <= 1'b1;
            if (rd_node_ff == id_ff) hit_ff <= 1'b1;
         end
         if (ctl.finish && fin_emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               REG_DECAY_FACTOR:   factor_ff <= csr_data;
               REG_KEEP_THRESHOLD: thr_ff    <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_outcome        = out_outcome_ff;
   assign rsp_slot_index     = out_slot_ff;
   assign rsp_displaced_node = out_disp_ff;
   assign rsp_occupied       = out_occ_ff;

   `SST_ASSERT(a_used_bound, clock, reset, used_ff <= CW'(SLOTS))
   `SST_ASSERT(a_compact_behind_read, clock, reset, k_ff <= ptr_ff)
   `SST_ASSERT(a_finish_pipe_empty, clock, reset, !ctl.finish || !(v1_ff || v2_ff))
   `SST_ASSERT_NEXT(a_load_restarts, clock, reset, ctl.load, ptr_ff == '0 && k_ff == '0)

endmodule

@@ sv/salience_slot_table_core.sv @@
// salience slot table top level: joins the controller and the datapath
// depends on sst_pkg, sst_if, sst_ctrl and sst_dpath
// a request steps through the sweep, drain and finish states; insert and decay read each
// occupied slot in the sweep, decay also passes through the decay product register, clear reads none
// throughput: one request in flight; the next is taken in idle, entered as the result is
// registered; a result still waiting holds the finish step. reads one slot per cycle
// reset: synchronous, clears the table count and restores register defaults
module salience_slot_table_core import sst_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic  clock,
   input  logic  reset,
   sst_req_if.sink   req,
   sst_rsp_if.source rsp,
   sst_csr_if.sink   csr
);

   ctl_type ctl;
   sts_type sts;

   assign csr.ready = 1'b1;

   sst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   sst_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_command        (req.command),
      .req_node_id        (req.node_id),
      .req_salience       (req.salience),
      .csr_valid          (csr.valid),
      .csr_index          (csr.index),
      .csr_data           (csr.data),
      .rsp_valid          (rsp.valid),
      .rsp_ready          (rsp.ready),
      .rsp_outcome        (rsp.outcome),
      .rsp_slot_index     (rsp.slot_index),
      .rsp_displaced_node (rsp.displaced_node),
      .rsp_occupied       (rsp.occupied)
   );

endmodule
